/* rtl/core/upe_pkg.sv */
// Shared types, character codes and helpers for the URL percent encoder.
// No dependencies; every other file of the block but upe_ifs imports this package.
package upe_pkg;

  // Keep-set selector held in the configuration register.
  typedef enum logic [1:0] {
    TBL_RFC3986  = 2'd0,
    TBL_HTML5    = 2'd1,
    TBL_WWW_FORM = 2'd2,
    TBL_UNUSED   = 2'd3
  } tbl_t;

  localparam int CFG_W       = 2;
  localparam int BYTE_W      = 8;
  localparam int QUEUE_DEPTH = 2;

  // How the back end expands a queued item.
  typedef enum logic {
    KIND_KEEP = 1'b0,
    KIND_ESC  = 1'b1
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [BYTE_W-1:0]  data;   // kept value, or raw byte to escape
    logic               fin;    // final item of the message
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

  localparam logic [BYTE_W-1:0] CH_PCT   = 8'h25;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_DASH  = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_DOT   = 8'h2E;
  localparam logic [BYTE_W-1:0] CH_UNDER = 8'h5F;
  localparam logic [BYTE_W-1:0] CH_TILDE = 8'h7E;
  localparam logic [BYTE_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [BYTE_W-1:0] CH_AMP   = 8'h26;
  localparam logic [BYTE_W-1:0] CH_EQ    = 8'h3D;

  // Upper-case hex digit for one nibble.
  function automatic logic [BYTE_W-1:0] hex_digit(input logic [3:0] nib);
    logic [BYTE_W-1:0] wide;
    wide = {4'h0, nib};
    return (nib < 4'd10) ? (8'h30 + wide) : (8'h37 + wide);
  endfunction

endpackage

/* rtl/core/upe_ifs.sv */
// Valid/ready channel interfaces for the URL percent encoder.
// Input channel carries a raw byte, result channel an encoded byte.
// No dependencies.
interface upe_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       end_in;

  modport source (output valid, output in_byte, output end_in, input ready);
  modport sink   (input valid, input in_byte, input end_in, output ready);
endinterface

interface upe_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_run;
  logic       end_out;

  modport source (output valid, output out_byte, output last_of_run,
                  output end_out, input ready);
  modport sink   (input valid, input out_byte, input last_of_run,
                  input end_out, output ready);
endinterface

/* rtl/core/upe_front.sv */
// Front end: holds the keep-set register, accepts input items and
// classifies each as kept or escaped. Depends on upe_pkg and upe_ifs.
module upe_front (
  input  logic                       clk,
  input  logic                       rst_n,
  upe_in_if.sink                     in_ch,
  input  logic                       cfg_we,
  input  logic [upe_pkg::CFG_W-1:0]  cfg_wdata,
  input  upe_pkg::q_stat_t           q_stat,
  output logic                       push,
  output upe_pkg::q_entry_t          push_entry
);
  import upe_pkg::*;

  tbl_t              tbl_r;
  tbl_t              tbl_nxt;
  logic [BYTE_W-1:0] b;
  logic              alnum;
  logic              keep;
  logic [BYTE_W-1:0] kept_val;

  always_comb begin
    tbl_nxt = cfg_we ? tbl_t'(cfg_wdata) : tbl_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tbl_r <= TBL_RFC3986;
    end else begin
      tbl_r <= tbl_nxt;
    end
  end

  assign b     = in_ch.in_byte;
  assign alnum = (b >= 8'h30 && b <= 8'h39) || (b >= 8'h41 && b <= 8'h5A) ||
                 (b >= 8'h61 && b <= 8'h7A);

  always_comb begin
    kept_val = b;
    keep     = 1'b0;
    if (alnum || b == CH_DASH || b == CH_DOT || b == CH_UNDER) begin
      keep = 1'b1;
    end else begin
      case (tbl_r)
        TBL_RFC3986: keep = (b == CH_TILDE);
        TBL_HTML5: begin
          if (b == CH_SPACE) begin
            keep     = 1'b1;
            kept_val = CH_PLUS;
          end else begin
            keep = (b == CH_STAR);
          end
        end
        TBL_WWW_FORM: keep = (b == CH_STAR) || (b == CH_AMP) || (b == CH_EQ);
        default:      keep = 1'b0;
      endcase
    end
  end

  // Take an item whenever the queue has room; drop it under the unused selector.
  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full && (tbl_r != TBL_UNUSED);

  always_comb begin
    push_entry.kind = keep ? KIND_KEEP : KIND_ESC;
    push_entry.data = keep ? kept_val : b;
    push_entry.fin  = in_ch.end_in;
  end

  a_no_push_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (tbl_r == TBL_UNUSED) |-> !push)
    else $error("item queued under the unused selector");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (in_ch.valid && in_ch.ready))
    else $error("queue write without an accepted item");

  a_cfg_takes: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |=> (tbl_r == tbl_t'($past(cfg_wdata))))
    else $error("keep-set register missed a write");

endmodule

/* rtl/core/upe_queue.sv */
// Short item queue between front and back end of the URL percent encoder.
// Depends on upe_pkg.
module upe_queue #(
  parameter int QDEPTH = upe_pkg::QUEUE_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  upe_pkg::q_entry_t  push_entry,
  input  logic               pop,
  output upe_pkg::q_entry_t  head,
  output upe_pkg::q_stat_t   stat
);
  import upe_pkg::*;

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QDEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QDEPTH);

  q_entry_t         mem_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == FULL_CNT);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full))
    else $error("write into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("read from an empty queue");

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("queue count beyond depth");

endmodule

/* rtl/core/upe_back.sv */
// Back end: expands queued items into one or three result bytes and holds
// them in the output register. Depends on upe_pkg and upe_ifs.
module upe_back (
  input  logic               clk,
  input  logic               rst_n,
  input  upe_pkg::q_entry_t  q_head,
  input  upe_pkg::q_stat_t   q_stat,
  output logic               pop,
  upe_out_if.source          out_ch
);
  import upe_pkg::*;

  typedef enum logic [1:0] {
    PH_PCT = 2'd0,
    PH_HI  = 2'd1,
    PH_LO  = 2'd2
  } phase_t;

  phase_t            phase_r, phase_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [BYTE_W-1:0] out_byte_r, out_byte_nxt;
  logic              last_r, last_nxt;
  logic              end_r, end_nxt;
  logic              load;

  // Refill the output register when it is empty or being taken.
  assign load = !out_valid_r || out_ch.ready;

  always_comb begin
    phase_nxt     = phase_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    last_nxt      = last_r;
    end_nxt       = end_r;
    pop           = 1'b0;
    if (load) begin
      out_valid_nxt = !q_stat.empty;
      if (!q_stat.empty) begin
        if (q_head.kind == KIND_KEEP) begin
          out_byte_nxt = q_head.data;
          last_nxt     = 1'b1;
          end_nxt      = q_head.fin;
          pop          = 1'b1;
          phase_nxt    = PH_PCT;
        end else begin
          case (phase_r)
            PH_PCT: begin
              out_byte_nxt = CH_PCT;
              last_nxt     = 1'b0;
              end_nxt      = 1'b0;
              phase_nxt    = PH_HI;
            end
            PH_HI: begin
              out_byte_nxt = hex_digit(q_head.data[7:4]);
              last_nxt     = 1'b0;
              end_nxt      = 1'b0;
              phase_nxt    = PH_LO;
            end
            PH_LO: begin
              out_byte_nxt = hex_digit(q_head.data[3:0]);
              last_nxt     = 1'b1;
              end_nxt      = q_head.fin;
              pop          = 1'b1;
              phase_nxt    = PH_PCT;
            end
            default: begin
              phase_nxt     = PH_PCT;
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_PCT;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_byte_r <= out_byte_nxt;
    last_r     <= last_nxt;
    end_r      <= end_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.last_of_run = last_r;
  assign out_ch.end_out     = end_r;

  a_mid_escape: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r != PH_PCT) |-> (!q_stat.empty && q_head.kind == KIND_ESC))
    else $error("escape sequence lost its queue entry");

  a_pop_on_load: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (load && !q_stat.empty))
    else $error("queue read while the output register is held");

  a_stall_holds_phase: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready) |=> (phase_r == $past(phase_r)))
    else $error("phase moved during an output stall");

  a_end_only_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && end_r) |-> last_r)
    else $error("end flag on a byte that is not last of its run");

endmodule

/* rtl/core/url_percent_encoder.sv */
// URL percent encoder, top level.
// Depends on upe_pkg, upe_ifs, upe_front, upe_queue and upe_back.
//
// Usage:
//   in_ch   valid/ready channel, one raw byte per item plus end_in on the
//           final byte of a message.
//   out_ch  valid/ready channel, one encoded byte per item. A kept byte gives
//           one item; any other gives '%' and two upper-case hex digits.
//           last_of_run marks the final byte of each input's run, end_out the
//           final byte of the message.
//   cfg_we/cfg_wdata write the keep-set selector: 0 RFC 3986 unreserved,
//           1 HTML5 form (space becomes '+'), 2 x-www-form. Under 3 every
//           input item is taken and dropped. Write only while idle.
// Path: an accepted item is written into the queue, then its first result byte
//   is loaded from the queue head into the output register, when the path is clear.
// Throughput: one result byte per cycle while the receiver is ready, set by the
//   single output register; a kept byte gives one result byte, an escaped byte three.
// The front end accepts a new item in any cycle the queue has room, so the
//   input keeps moving while an escape sequence drains.
// Reset clears the selector to RFC 3986, empties the queue and the output.
// A stalled receiver holds the output item; the queue fills, then in_ch
//   drops ready until the back end frees a slot.
module url_percent_encoder #(
  parameter int QDEPTH = upe_pkg::QUEUE_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst_n,
  upe_in_if.sink                     in_ch,
  upe_out_if.source                  out_ch,
  input  logic                       cfg_we,
  input  logic [upe_pkg::CFG_W-1:0]  cfg_wdata
);
  import upe_pkg::*;

  q_stat_t  q_stat;
  q_entry_t push_entry;
  q_entry_t q_head;
  logic     push;
  logic     pop;

  // Classify and admit items; hold the keep-set selector.
  upe_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_stat     (q_stat),
    .push       (push),
    .push_entry (push_entry)
  );

  // Decouple admission from expansion so each side stalls on its own.
  upe_queue #(
    .QDEPTH (QDEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (q_head),
    .stat       (q_stat)
  );

  // Expand each entry into its result bytes, one per cycle while the output is not stalled.
  upe_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_ch (out_ch)
  );

endmodule

/* dv/url_percent_encoder_test.sv */
`timescale 1ns / 100ps
// Self-checking bench for url_percent_encoder: drives raw bytes under every keep set
// and checks each encoded byte against a predictor of the escaping rules.
// Depends on upe_pkg, upe_ifs and the encoder RTL.

module url_percent_encoder_test;
  import upe_pkg::*;

  localparam int CLK_HALF      = 4;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 6;
  localparam int MAX_SHOWN     = 10;

  // One raw byte waiting to be driven, and one encoded byte waiting to arrive.
  typedef struct {
    logic [7:0] raw;
    logic       fin;
  } raw_item_t;

  typedef struct {
    logic [7:0] chr;
    logic       run_end;
    logic       msg_end;
  } enc_item_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_W-1:0]     cfg_wdata;

  upe_in_if  in_ch ();
  upe_out_if out_ch ();

  url_percent_encoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  raw_item_t raw_q[$];     // bytes still to be offered on the input channel
  enc_item_t enc_q[$];     // encoded bytes the block still owes us
  tbl_t      active_tbl;   // our own copy of the keep-set selector
  int        in_flight;    // 1 while an item sits on the input channel
  int        in_gap;       // remaining idle cycles of a sender burst
  int        out_stall;    // remaining stall cycles of a receiver burst
  int        mismatches;
  int        cycles;
  bit        calm;         // set for the closing phase: no idling at all

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic bit is_alnum(logic [7:0] b);
    return (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
  endfunction

  // Byte to pass through for a kept input; zero means the input must be escaped.
  // A zero input never counts as kept, so zero is free to act as the marker.
  function automatic logic [7:0] kept_char(tbl_t t, logic [7:0] b);
    if (is_alnum(b) || b == CH_DASH || b == CH_DOT || b == CH_UNDER) return b;
    case (t)
      TBL_RFC3986:  return (b == CH_TILDE) ? b : 8'h00;
      TBL_HTML5: begin
        if (b == CH_SPACE) return CH_PLUS;
        return (b == CH_STAR) ? b : 8'h00;
      end
      TBL_WWW_FORM: return (b == CH_STAR || b == CH_AMP || b == CH_EQ) ? b : 8'h00;
      default:      return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] nibble_char(logic [3:0] n);
    logic [7:0] wide;
    wide = {4'h0, n};
    if (n > 4'd9) return "A" + wide - 8'd10;
    return "0" + wide;
  endfunction

  // Queue up the encoded bytes that one accepted input must produce.
  function automatic void predict_encoding(logic [7:0] b, logic fin);
    logic [7:0] k;
    if (active_tbl == TBL_UNUSED) return;  // unused selector: input is swallowed
    k = kept_char(active_tbl, b);
    if (k != 8'h00) begin
      enc_q.push_back('{k, 1'b1, fin});
    end else begin
      enc_q.push_back('{CH_PCT, 1'b0, 1'b0});
      enc_q.push_back('{nibble_char(b[7:4]), 1'b0, 1'b0});
      enc_q.push_back('{nibble_char(b[3:0]), 1'b1, fin});
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: changes at the falling edge, one item at a time from raw_q.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    raw_item_t nxt;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (in_flight == 0) begin
      if (in_gap > 0) begin
        // Sit out the rest of the current idle burst.
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (raw_q.size() == 0) begin
        in_ch.valid <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        // Open a burst of idle cycles of random length; this cycle is the first.
        in_gap = $urandom_range(0, 16);
        in_ch.valid <= 1'b0;
      end else begin
        nxt = raw_q.pop_front();
        in_ch.valid  <= 1'b1;
        in_ch.in_byte <= nxt.raw;
        in_ch.end_in <= nxt.fin;
        in_flight = 1;
      end
    end
    // Otherwise hold the item until the block takes it.
  end

  // ---------------------------------------------------------------------------
  // Receiver back-pressure: ready stalls in bursts of random length.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      out_stall = $urandom_range(0, 16);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: sample both handshakes at the rising edge.
  // ---------------------------------------------------------------------------
  function automatic void log_mismatch(string what);
    mismatches++;
    if (mismatches <= MAX_SHOWN) $display("[%0d] %s", cycles, what);
  endfunction

  always @(posedge clk) begin
    enc_item_t want;
    cycles++;
    if (rst_n) begin
      // Predict on acceptance, so the selector in force at that edge applies.
      if (in_ch.valid && in_ch.ready) begin
        predict_encoding(in_ch.in_byte, in_ch.end_in);
        in_flight = 0;
      end
      if (out_ch.valid && out_ch.ready) begin
        if (enc_q.size() == 0) begin
          log_mismatch($sformatf("unexpected byte %02h last %b end %b", out_ch.out_byte,
                                 out_ch.last_of_run, out_ch.end_out));
        end else begin
          want = enc_q.pop_front();
          if (out_ch.out_byte !== want.chr || out_ch.last_of_run !== want.run_end ||
              out_ch.end_out !== want.msg_end)
            log_mismatch($sformatf("expected %02h/%b/%b got %02h/%b/%b",
                                   want.chr, want.run_end, want.msg_end,
                                   out_ch.out_byte, out_ch.last_of_run, out_ch.end_out));
        end
      end
    end
  end

  // Drop the run if it hangs.
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  function automatic void add_item(logic [7:0] b, logic fin);
    raw_q.push_back('{b, fin});
  endfunction

  // Bias the bytes towards the interesting corners of the keep sets.
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 4))
      0: return 8'($urandom_range(0, 255));
      1: return 8'($urandom_range(128, 255));
      2: begin
        case ($urandom_range(0, 9))
          0: return CH_DASH;
          1: return CH_DOT;
          2: return CH_UNDER;
          3: return CH_TILDE;
          4: return CH_STAR;
          5: return CH_AMP;
          6: return CH_EQ;
          7: return CH_SPACE;
          8: return CH_PLUS;
          default: return CH_PCT;
        endcase
      end
      3: begin
        case ($urandom_range(0, 2))
          0: return "a" + 8'($urandom_range(0, 25));
          1: return "A" + 8'($urandom_range(0, 25));
          default: return "0" + 8'($urandom_range(0, 9));
        endcase
      end
      default: return 8'($urandom_range(0, 31));
    endcase
  endfunction

  // Block until every byte has been taken and every result has come back,
  // then let the back end settle (swallowed items produce nothing to wait on).
  task automatic wait_idle();
    do @(negedge clk);
    while (raw_q.size() != 0 || in_flight != 0 || enc_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Write the selector while the block is idle and track it in the predictor.
  task automatic set_table(tbl_t t);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= t;
    @(negedge clk);
    cfg_we    <= 1'b0;
    active_tbl = t;
  endtask

  // Mostly well-formed messages of random length; now and then the end marker
  // is left off so that a message runs on into the next.
  task automatic random_phase(tbl_t t, int n_items);
    int sent;
    int len;
    set_table(t);
    sent = 0;
    while (sent < n_items) begin
      len = $urandom_range(1, 12);
      for (int i = 0; i < len; i++)
        add_item(pick_byte(), (i == len - 1) && ($urandom_range(0, 9) != 0));
      sent += len;
    end
    wait_idle();
  endtask

  initial begin
    rst_n          = 1'b0;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    in_ch.valid    = 1'b0;
    in_ch.in_byte  = '0;
    in_ch.end_in   = 1'b0;
    out_ch.ready   = 1'b0;
    active_tbl     = TBL_RFC3986;
    in_flight      = 0;
    in_gap         = 0;
    out_stall      = 0;
    mismatches     = 0;
    cycles         = 0;
    calm           = 1'b0;

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // RFC 3986: zero byte mid-message, high bytes, edges of the alnum ranges
    // and every kept punctuation mark.
    set_table(TBL_RFC3986);
    add_item(8'h00, 1'b0);
    add_item(8'hFF, 1'b0);
    add_item(8'h80, 1'b0);
    add_item(8'h7F, 1'b0);
    add_item("A", 1'b0);
    add_item("Z", 1'b0);
    add_item("a", 1'b0);
    add_item("z", 1'b0);
    add_item("0", 1'b0);
    add_item("9", 1'b0);
    add_item(CH_DASH, 1'b0);
    add_item(CH_DOT, 1'b0);
    add_item(CH_UNDER, 1'b0);
    add_item(CH_TILDE, 1'b1);
    wait_idle();

    // HTML5 form: space turns into plus, star kept, tilde escaped.
    set_table(TBL_HTML5);
    add_item(CH_SPACE, 1'b0);
    add_item(CH_STAR, 1'b0);
    add_item(CH_TILDE, 1'b0);
    add_item(CH_PLUS, 1'b1);
    wait_idle();

    // x-www-form: star, ampersand and equals kept, space escaped.
    set_table(TBL_WWW_FORM);
    add_item(CH_STAR, 1'b0);
    add_item(CH_AMP, 1'b0);
    add_item(CH_EQ, 1'b0);
    add_item(CH_SPACE, 1'b1);
    wait_idle();

    // Unused selector: items are taken and dropped, end marker included.
    set_table(TBL_UNUSED);
    add_item("A", 1'b0);
    add_item(8'hFF, 1'b1);
    wait_idle();

    random_phase(TBL_WWW_FORM, 20);
    random_phase(TBL_RFC3986, 20);
    random_phase(TBL_HTML5, 20);
    random_phase(TBL_UNUSED, 10);
    random_phase(TBL_HTML5, 20);
    calm = 1'b1;
    random_phase(TBL_RFC3986, 20);

    if (mismatches == 0 && enc_q.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
